// File: design/ple_pkg.sv
package ple_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the ports
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_REMOVE = 2'd3
  } ple_act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_PUT,
    S_FETCH,
    S_DONE
  } ple_state_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } ple_ram_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } ple_res_t;

endpackage

// File: design/positional_list_engine.sv
// Bounded positional list: up to 16 words of 32 bits held in order.
// Input beat (in_valid/in_stall): in_action selects append, insert at
// in_position, read at in_position or remove at in_position; in_value is
// the word for append and insert. Every input beat yields exactly one
// output beat (out_valid/out_stall) with out_data_out, out_ok, out_count.
// Rejected actions (bad position, add into a full list) give out_ok 0,
// out_data_out 0 and leave the list untouched.
// Elements live in a single-port-write, registered-read RAM; insert and
// remove move the later elements one at a time through that RAM, with
// one read and one write per element moved.
// in_stall is high while an item is being worked on, so one item is in
// flight at a time; the output beat sits in its own register, so the next
// input beat can be taken while the last result still waits.
// Reset (rst_n low, synchronous) empties the list; slot contents are not
// cleared as a slot is only read once it has been written.
// If the receiver stalls, the output beat holds and the block finishes
// at most one further item, then waits.
module positional_list_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [ple_pkg::POS_W-1:0]      in_position,
  input  logic [ple_pkg::VALUE_W-1:0]    in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ple_pkg::VALUE_W-1:0]    out_data_out,
  output logic                           out_ok,
  output logic [ple_pkg::COUNT_W-1:0]    out_count
);

  import ple_pkg::*;

  ple_ram_req_t          ram_req;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  busy;
  logic                  res_valid;
  logic                  res_take;
  ple_res_t              res;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  ple_res_t              out_res_r, out_res_nxt;

  ple_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (ple_act_t'(in_action)),
    .in_position (in_position),
    .in_value    (in_value),
    .busy        (busy),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // The result moves into the output register whenever that is free or
  // being emptied this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign in_stall     = busy;
  assign out_valid    = out_valid_r;
  assign out_data_out = out_res_r.data;
  assign out_ok       = out_res_r.ok;
  assign out_count    = out_res_r.count;

endmodule

// File: design/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/ple_ctrl.sv
module ple_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  ple_pkg::ple_act_t                    in_action,
  input  logic [ple_pkg::POS_W-1:0]            in_position,
  input  logic [ple_pkg::VALUE_W-1:0]          in_value,
  output logic                                 busy,
  output ple_pkg::ple_ram_req_t                ram_req,
  input  logic [ple_pkg::DATA_WIDTH-1:0]       ram_rdata,
  output logic                                 res_valid,
  output ple_pkg::ple_res_t                    res,
  input  logic                                 res_take
);

  import ple_pkg::*;

  ple_state_t            state_r, state_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0]     stop_r, stop_nxt;
  logic                  rm_r, rm_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] res_data_r, res_data_nxt;
  logic                  res_ok_r, res_ok_nxt;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, ins_pos;
  logic              is_add, full, put_ok, get_ok;
  logic [ADDR_W-1:0] nbr;

  // Accept-time checks
  assign is_add  = (in_action == ACT_APPEND) || (in_action == ACT_INSERT);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign ins_pos = (in_action == ACT_APPEND) ? cnt_ext : pos_ext;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign put_ok  = !full && (ins_pos <= cnt_ext);
  assign get_ok  = pos_ext < cnt_ext;

  // Shared index step: up while closing a gap, down while opening one
  assign nbr = rm_r ? (idx_r + ADDR_W'(1)) : (idx_r - ADDR_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_add) begin
            if (!put_ok) begin
              state_nxt = S_DONE;
            end else if (ins_pos == cnt_ext) begin
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_RD;
            end
          end else begin
            state_nxt = get_ok ? S_FETCH : S_DONE;
          end
        end
      end
      S_RD:    state_nxt = S_WR;
      S_WR: begin
        if (nbr == stop_r) begin
          state_nxt = rm_r ? S_DONE : S_PUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_PUT:   state_nxt = S_DONE;
      S_FETCH: state_nxt = (!rm_r || (idx_r == stop_r)) ? S_DONE : S_RD;
      S_DONE:  state_nxt = res_take ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    stop_nxt      = stop_r;
    rm_nxt        = rm_r;
    word_nxt      = word_r;
    count_nxt     = count_r;
    res_data_nxt  = res_data_r;
    res_ok_nxt    = res_ok_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_r;
    ram_req.wdata = ram_rdata;
    ram_req.raddr = nbr;
    case (state_r)
      S_IDLE: begin
        ram_req.raddr = ADDR_W'(in_position);
        if (in_valid) begin
          word_nxt     = DATA_WIDTH'(in_value);
          rm_nxt       = (in_action == ACT_REMOVE);
          res_data_nxt = '0;
          if (is_add) begin
            res_ok_nxt = put_ok;
            idx_nxt    = ADDR_W'(count_r);
            stop_nxt   = ADDR_W'(ins_pos);
          end else begin
            res_ok_nxt = get_ok;
            idx_nxt    = ADDR_W'(in_position);
            stop_nxt   = ADDR_W'(count_r - CNT_W'(1));
          end
        end
      end
      S_RD: begin
        ram_req.raddr = nbr;
      end
      S_WR: begin
        ram_req.we = 1'b1;
        idx_nxt    = nbr;
        if (rm_r && (nbr == stop_r)) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = stop_r;
        ram_req.wdata = word_r;
        count_nxt     = count_r + CNT_W'(1);
      end
      S_FETCH: begin
        res_data_nxt = ram_rdata;
        if (rm_r && (idx_r == stop_r)) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    stop_r     <= stop_nxt;
    rm_r       <= rm_nxt;
    word_r     <= word_nxt;
    res_data_r <= res_data_nxt;
    res_ok_r   <= res_ok_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.data  = VALUE_W'(res_data_r);
  assign res.ok    = res_ok_r;
  assign res.count = COUNT_W'(count_r);

endmodule
